>>> hdl/smof_pkg.sv
// Shared constants and types of the scan median outlier filter.
package smof_pkg;

	localparam int WINDOW_LEN = 9;
	localparam int HALF_LEN   = WINDOW_LEN / 2;
	localparam int RANGE_BITS = 16;
	localparam int MM_W       = 16;
	localparam int INDEX_W    = 16;
	localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
	localparam int TAIL_W     = $clog2(HALF_LEN + 1);
	localparam int QDEPTH     = 8;
	localparam int QA_W       = $clog2(QDEPTH);
	localparam int USED_W     = $clog2(QDEPTH + 1);

	// window cell: invalid flag above the range bits
	typedef logic [RANGE_BITS:0] cell_t;
	typedef cell_t [WINDOW_LEN-1:0] window_t;

	typedef struct packed {
		logic              has_main;
		logic              use_med;
		logic [TAIL_W-1:0] tail_cnt;
	} cls_t;

	typedef struct packed {
		logic [RANGE_BITS-1:0] med_mm;
		logic                  med_invalid;
		logic                  has_main;
		logic [TAIL_W-1:0]     tail_cnt;
	} qent_t;

endpackage

>>> hdl/scan_median_outlier_filter.sv
// Scan median outlier filter: 9-sample sliding median over laser range words,
// NaN-aware, with a NaN tail flushed at scan end. One sample word is taken each
// clock unless sample_stall is high; each sample gives at most one result word
// except the last of a scan, which gives up to five, and the output port moves
// one result word per clock unless result_stall holds it, so that port sets the
// sustained rate. Accepted words pass the window, rank and queue registers to
// the output register. An eight-word queue between the rank stage and the
// result sequencer, tracked by credits in the front end, lets input flow while
// output stalls; sample_stall rises once eight words are in flight or waiting.
module scan_median_outlier_filter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      sample_valid,
	output logic                      sample_stall,
	input  logic [smof_pkg::MM_W-1:0] range_mm,
	input  logic                      range_invalid,
	input  logic                      scan_last,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [smof_pkg::MM_W-1:0] filtered_mm,
	output logic                      filtered_invalid,
	output logic                      scan_done
);
	import smof_pkg::*;

	window_t window;
	cls_t    cls_s1;
	logic    valid_s1;
	logic    push;
	logic    drop;
	logic    pop;
	qent_t   qent;

	smof_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.range_mm     (range_mm),
		.range_invalid(range_invalid),
		.scan_last    (scan_last),
		.release_pop  (pop),
		.release_drop (drop),
		.window       (window),
		.cls_s1       (cls_s1),
		.valid_s1     (valid_s1)
	);

	smof_rank u_rank (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_s1(valid_s1),
		.window  (window),
		.cls_s1  (cls_s1),
		.push    (push),
		.drop    (drop),
		.qent    (qent)
	);

	smof_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.qent            (qent),
		.pop             (pop),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.filtered_mm     (filtered_mm),
		.filtered_invalid(filtered_invalid),
		.scan_done       (scan_done)
	);

endmodule

>>> hdl/smof_front.sv
// Front end: accepts samples, shifts the window, tracks scan position and queue credit.
module smof_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic [smof_pkg::MM_W-1:0]     range_mm,
	input  logic                          range_invalid,
	input  logic                          scan_last,
	input  logic                          release_pop,
	input  logic                          release_drop,
	output smof_pkg::window_t             window,
	output smof_pkg::cls_t                cls_s1,
	output logic                          valid_s1
);
	import smof_pkg::*;

	window_t            window_q;
	logic [INDEX_W-1:0] idx_q;
	logic [USED_W-1:0]  used_q;
	logic               acc;
	cls_t               cls;

	assign sample_stall = (used_q == USED_W'(QDEPTH));
	assign acc          = sample_valid && !sample_stall;
	assign window       = window_q;

	always_comb begin
		cls.has_main = (idx_q >= INDEX_W'(HALF_LEN));
		cls.use_med  = (idx_q >= INDEX_W'(2 * HALF_LEN));
		if (!scan_last) begin
			cls.tail_cnt = '0;
		end else if (idx_q < INDEX_W'(HALF_LEN)) begin
			cls.tail_cnt = TAIL_W'(idx_q + INDEX_W'(1));
		end else begin
			cls.tail_cnt = TAIL_W'(HALF_LEN);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			for (int a = WINDOW_LEN - 1; a > 0; a--) begin
				window_q[a] <= window_q[a-1];
			end
			window_q[0] <= {range_invalid, range_mm[RANGE_BITS-1:0]};
			cls_s1      <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			used_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
			used_q   <= used_q + USED_W'(acc) - USED_W'(release_pop) - USED_W'(release_drop);
			if (acc) begin
				if (scan_last) begin
					idx_q <= '0;
				end else if (idx_q != {INDEX_W{1'b1}}) begin
					idx_q <= idx_q + INDEX_W'(1);
				end
			end
		end
	end

endmodule

>>> hdl/smof_rank.sv
// Rank stage: per-cell rank counts, median select and queue word build.
module smof_rank (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  smof_pkg::window_t window,
	input  smof_pkg::cls_t    cls_s1,
	output logic              push,
	output logic              drop,
	output smof_pkg::qent_t   qent
);
	import smof_pkg::*;

	logic [RANGE_BITS-1:0] val_s2   [WINDOW_LEN];
	logic [WINDOW_LEN-1:0] vld_s2;
	logic [CNT_W-1:0]      below_s2 [WINDOW_LEN];
	logic [CNT_W-1:0]      upto_s2  [WINDOW_LEN];
	logic [CNT_W-1:0]      nv_s2;
	cls_t                  cls_s2;
	logic                  valid_s2;

	logic [CNT_W-1:0]      below    [WINDOW_LEN];
	logic [CNT_W-1:0]      upto     [WINDOW_LEN];
	logic [CNT_W-1:0]      nv;
	logic [CNT_W-1:0]      rank;
	logic [RANGE_BITS-1:0] sel;
	logic                  ok;
	logic                  med_inv;
	logic                  any;

	always_comb begin
		nv = '0;
		for (int a = 0; a < WINDOW_LEN; a++) begin
			nv = nv + CNT_W'(!window[a][RANGE_BITS]);
			below[a] = '0;
			upto[a]  = '0;
			for (int b = 0; b < WINDOW_LEN; b++) begin
				if (!window[b][RANGE_BITS]) begin
					below[a] = below[a] +
						CNT_W'(window[b][RANGE_BITS-1:0] < window[a][RANGE_BITS-1:0]);
					upto[a]  = upto[a] +
						CNT_W'(window[b][RANGE_BITS-1:0] <= window[a][RANGE_BITS-1:0]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int a = 0; a < WINDOW_LEN; a++) begin
				val_s2[a]   <= window[a][RANGE_BITS-1:0];
				vld_s2[a]   <= !window[a][RANGE_BITS];
				below_s2[a] <= below[a];
				upto_s2[a]  <= upto[a];
			end
			nv_s2  <= nv;
			cls_s2 <= cls_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// equal values may match at several cells; they carry the same value
	always_comb begin
		rank = nv_s2 >> 1;
		sel  = '0;
		for (int a = 0; a < WINDOW_LEN; a++) begin
			if (vld_s2[a] && below_s2[a] <= rank && rank < upto_s2[a]) begin
				sel = sel | val_s2[a];
			end
		end
		ok      = (nv_s2 != '0) && ({nv_s2, 1'b0} >= (CNT_W + 1)'(WINDOW_LEN));
		med_inv = !(cls_s2.use_med && ok);
		any     = cls_s2.has_main || (cls_s2.tail_cnt != '0);
	end

	assign push             = valid_s2 && any;
	assign drop             = valid_s2 && !any;
	assign qent.med_mm      = med_inv ? '0 : sel;
	assign qent.med_invalid = med_inv;
	assign qent.has_main    = cls_s2.has_main;
	assign qent.tail_cnt    = cls_s2.tail_cnt;

endmodule

>>> hdl/smof_back.sv
// Back end: word queue and result sequencer with registered output.
module smof_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  smof_pkg::qent_t           qent,
	output logic                      pop,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [smof_pkg::MM_W-1:0] filtered_mm,
	output logic                      filtered_invalid,
	output logic                      scan_done
);
	import smof_pkg::*;

	qent_t             fifo_q [QDEPTH];
	logic [QA_W-1:0]   wr_ptr_q;
	logic [QA_W-1:0]   rd_ptr_q;
	logic [USED_W-1:0] cnt_q;
	logic              main_sent_q;
	logic [TAIL_W-1:0] tail_sent_q;
	logic              result_valid_q;
	logic [MM_W-1:0]   mm_q;
	logic              inv_q;
	logic              done_q;

	qent_t             head;
	logic              out_free;
	logic              emit;
	logic              emit_main;
	logic              tail_end;
	logic              last;

	assign head      = fifo_q[rd_ptr_q];
	assign out_free  = !result_valid_q || !result_stall;
	assign emit      = out_free && (cnt_q != '0);
	assign emit_main = head.has_main && !main_sent_q;
	assign tail_end  = (tail_sent_q + TAIL_W'(1)) == head.tail_cnt;
	assign last      = emit_main ? (head.tail_cnt == '0) : tail_end;
	assign pop       = emit && last;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= qent;
		end
		if (out_free && emit) begin
			if (emit_main) begin
				mm_q   <= MM_W'(head.med_mm);
				inv_q  <= head.med_invalid;
				done_q <= 1'b0;
			end else begin
				mm_q   <= '0;
				inv_q  <= 1'b1;
				done_q <= tail_end;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q       <= '0;
			rd_ptr_q       <= '0;
			cnt_q          <= '0;
			main_sent_q    <= 1'b0;
			tail_sent_q    <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QA_W'(1);
			end
			cnt_q <= cnt_q + USED_W'(push) - USED_W'(pop);
			if (out_free) begin
				result_valid_q <= emit;
			end
			if (emit) begin
				if (last) begin
					rd_ptr_q    <= rd_ptr_q + QA_W'(1);
					main_sent_q <= 1'b0;
					tail_sent_q <= '0;
				end else if (emit_main) begin
					main_sent_q <= 1'b1;
				end else begin
					tail_sent_q <= tail_sent_q + TAIL_W'(1);
				end
			end
		end
	end

	assign result_valid     = result_valid_q;
	assign filtered_mm      = mm_q;
	assign filtered_invalid = inv_q;
	assign scan_done        = done_q;

endmodule

>>> hdl/smof_check.sv
// Port-level assertions of the scan median outlier filter, bound to the top level.
module smof_check (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      sample_valid,
	input logic                      sample_stall,
	input logic [smof_pkg::MM_W-1:0] range_mm,
	input logic                      range_invalid,
	input logic                      scan_last,
	input logic                      result_valid,
	input logic                      result_stall,
	input logic [smof_pkg::MM_W-1:0] filtered_mm,
	input logic                      filtered_invalid,
	input logic                      scan_done
);

	a_sample_held: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_stall |=> sample_valid && $stable(range_mm) &&
			$stable(range_invalid) && $stable(scan_last))
		else $error("stalled sample word changed");

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word dropped while stalled");

	a_word_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(filtered_mm) &&
			$stable(filtered_invalid) && $stable(scan_done))
		else $error("stalled result word changed");

	a_nan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && filtered_invalid |-> filtered_mm == '0)
		else $error("NaN result with nonzero range");

	a_done_nan: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && scan_done |-> filtered_invalid)
		else $error("scan end flagged on a valid median");

endmodule

bind scan_median_outlier_filter smof_check u_smof_check (.*);
